>>> rtl/mhpd_pkg.sv
`default_nettype none

package mhpd_pkg;

    // Frame layout: byte positions within a frame
    localparam int HDR_BYTES   = 8;
    localparam int POS_SECOND  = 1;
    localparam int POS_VERSION = 2;
    localparam int POS_CMD     = 3;
    localparam int POS_SEQ     = 4;
    localparam int POS_FLAGS   = 5;
    localparam int POS_LEN_LO  = 6;

    localparam logic [7:0] IDLE_SAT = 8'd255;

    // Configuration register indexes
    localparam logic [1:0] CFG_FIRST_MAGIC  = 2'd0;
    localparam logic [1:0] CFG_SECOND_MAGIC = 2'd1;
    localparam logic [1:0] CFG_VERSION      = 2'd2;
    localparam logic [1:0] CFG_IDLE_LIMIT   = 2'd3;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_READ,
        ST_LOAD,
        ST_SUMMARY
    } state_t;

    typedef struct packed {
        logic take;          // input channel ready
        logic load_payload;  // load a payload word into the output register
        logic load_summary;  // load the summary word into the output register
    } cmd_t;

    typedef struct packed {
        logic frame_done;    // accepted byte completes a frame
        logic done_good;     // checksum of that frame holds
        logic has_payload;   // frame carries payload bytes
        logic last_byte;     // payload word being loaded is the final one
        logic slot_free;     // output register is empty or drains this cycle
    } status_t;

endpackage

`default_nettype wire

>>> rtl/mhpd_ram.sv
`default_nettype none

module mhpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/mhpd_ctrl.sv
`default_nettype none

module mhpd_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire mhpd_pkg::status_t status,
    output mhpd_pkg::cmd_t         cmd
);

    mhpd_pkg::state_t state_reg;
    mhpd_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mhpd_pkg::ST_HUNT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        cmd.take         = 1'b0;
        cmd.load_payload = 1'b0;
        cmd.load_summary = 1'b0;
        case (state_reg)
            mhpd_pkg::ST_HUNT: begin
                cmd.take = 1'b1;
                if (status.frame_done) begin
                    if (status.done_good && status.has_payload) begin
                        state_next = mhpd_pkg::ST_READ;
                    end else begin
                        state_next = mhpd_pkg::ST_SUMMARY;
                    end
                end
            end
            mhpd_pkg::ST_READ: begin
                // RAM address is already presented; go once the output slot frees
                if (status.slot_free) begin
                    state_next = mhpd_pkg::ST_LOAD;
                end
            end
            mhpd_pkg::ST_LOAD: begin
                cmd.load_payload = 1'b1;
                if (status.last_byte) begin
                    state_next = mhpd_pkg::ST_SUMMARY;
                end else begin
                    state_next = mhpd_pkg::ST_READ;
                end
            end
            mhpd_pkg::ST_SUMMARY: begin
                if (status.slot_free) begin
                    cmd.load_summary = 1'b1;
                    state_next       = mhpd_pkg::ST_HUNT;
                end
            end
            default: begin
                state_next = mhpd_pkg::ST_HUNT;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/mhpd_datapath.sv
`default_nettype none

module mhpd_datapath #(
    parameter int BUFFER_BYTES = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mhpd_pkg::cmd_t    cmd,
    output mhpd_pkg::status_t      status,
    input  wire logic              s_valid,
    input  wire logic              s_req_type,
    input  wire logic [7:0]        s_rx_byte,
    input  wire logic              cfg_write,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [7:0]        cfg_data,
    input  wire logic              m_ready,
    output logic                   m_valid,
    output logic                   m_is_summary,
    output logic [7:0]             m_payload_byte,
    output logic [5:0]             m_byte_index,
    output logic                   m_frame_status,
    output logic [7:0]             m_command_code,
    output logic [7:0]             m_sequence_number,
    output logic [7:0]             m_header_flags,
    output logic [5:0]             m_payload_count,
    output logic                   m_last
);

    localparam int FW = $clog2(BUFFER_BYTES + 1);
    localparam int AW = $clog2(BUFFER_BYTES);

    // configuration
    logic [7:0] first_magic_reg;
    logic [7:0] second_magic_reg;
    logic [7:0] version_cfg_reg;
    logic [7:0] idle_limit_reg;

    // parser state
    logic [FW-1:0] fill_reg,  fill_next;
    logic [FW-1:0] total_reg, total_next;
    logic [7:0]    idle_reg,  idle_next;
    logic [7:0]    xor_reg,   xor_next;
    logic [7:0]    ver_reg,   ver_next;
    logic [7:0]    cmd_reg,   cmd_next;
    logic [7:0]    seq_reg,   seq_next;
    logic [7:0]    flags_reg, flags_next;
    logic [7:0]    len_reg,   len_next;
    logic          good_reg;
    logic [AW-1:0] idx_reg;

    // output register
    logic       out_valid_reg;
    logic       out_summary_reg;
    logic [7:0] out_byte_reg;
    logic [5:0] out_index_reg;
    logic       out_status_reg;
    logic [7:0] out_cmd_reg;
    logic [7:0] out_seq_reg;
    logic [7:0] out_flags_reg;
    logic [5:0] out_count_reg;

    logic          accept;
    logic          store_we;
    logic          byte_done;
    logic          resync;
    logic          drop;
    logic [FW-1:0] fill_inc;
    logic [7:0]    idle_inc;
    logic [7:0]    ver_eff;
    logic [8:0]    total_sum;
    logic          too_big;
    logic [7:0]    ram_rdata;
    logic [AW-1:0] ram_raddr;

    assign accept    = s_valid && cmd.take;
    assign fill_inc  = fill_reg + 1'b1;
    assign idle_inc  = (idle_reg == mhpd_pkg::IDLE_SAT) ? idle_reg : idle_reg + 8'd1;
    assign ver_eff   = (fill_reg == FW'(mhpd_pkg::POS_VERSION)) ? s_rx_byte : ver_reg;
    assign total_sum = {1'b0, len_reg} + 9'(mhpd_pkg::HDR_BYTES + 1);
    // byte in hand is the length high byte; any nonzero value overflows the buffer
    assign too_big   = (s_rx_byte != 8'd0) || (total_sum > 9'(BUFFER_BYTES));
    assign ram_raddr = AW'(mhpd_pkg::HDR_BYTES) + idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_magic_reg  <= 8'd170;
            second_magic_reg <= 8'd85;
            version_cfg_reg  <= 8'd1;
            idle_limit_reg   <= 8'd100;
        end else if (cfg_write) begin
            case (cfg_index)
                mhpd_pkg::CFG_FIRST_MAGIC:  first_magic_reg  <= cfg_data;
                mhpd_pkg::CFG_SECOND_MAGIC: second_magic_reg <= cfg_data;
                mhpd_pkg::CFG_VERSION:      version_cfg_reg  <= cfg_data;
                mhpd_pkg::CFG_IDLE_LIMIT:   idle_limit_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        fill_next  = fill_reg;
        total_next = total_reg;
        idle_next  = idle_reg;
        xor_next   = xor_reg;
        ver_next   = ver_reg;
        cmd_next   = cmd_reg;
        seq_next   = seq_reg;
        flags_next = flags_reg;
        len_next   = len_reg;
        store_we   = 1'b0;
        byte_done  = 1'b0;
        resync     = 1'b0;
        drop       = 1'b0;

        if (accept && s_req_type) begin
            if (fill_reg != '0) begin
                if (idle_inc >= idle_limit_reg) begin
                    drop = 1'b1;
                end else begin
                    idle_next = idle_inc;
                end
            end
        end else if (accept) begin
            idle_next = 8'd0;
            if (fill_reg == '0) begin
                if (s_rx_byte == first_magic_reg) begin
                    fill_next = FW'(1);
                    xor_next  = s_rx_byte;
                end
            end else if (((fill_reg == FW'(mhpd_pkg::POS_SECOND)) &&
                          (s_rx_byte != second_magic_reg)) ||
                         (fill_reg >= FW'(BUFFER_BYTES))) begin
                resync = 1'b1;
            end else begin
                store_we  = 1'b1;
                fill_next = fill_inc;
                xor_next  = xor_reg ^ s_rx_byte;
                case (fill_reg)
                    FW'(mhpd_pkg::POS_VERSION): ver_next   = s_rx_byte;
                    FW'(mhpd_pkg::POS_CMD):     cmd_next   = s_rx_byte;
                    FW'(mhpd_pkg::POS_SEQ):     seq_next   = s_rx_byte;
                    FW'(mhpd_pkg::POS_FLAGS):   flags_next = s_rx_byte;
                    FW'(mhpd_pkg::POS_LEN_LO):  len_next   = s_rx_byte;
                    default: ;
                endcase
                // version byte is rechecked against the live register on every byte
                if ((fill_reg >= FW'(mhpd_pkg::POS_VERSION)) &&
                    (ver_eff != version_cfg_reg)) begin
                    resync = 1'b1;
                end else if ((fill_inc >= FW'(mhpd_pkg::HDR_BYTES)) &&
                             (total_reg == '0)) begin
                    if (too_big) begin
                        resync = 1'b1;
                    end else begin
                        total_next = FW'(total_sum);
                    end
                end else if ((total_reg != '0) && (fill_inc == total_reg)) begin
                    byte_done = 1'b1;
                    drop      = 1'b1;
                end
            end
        end

        if (resync) begin
            if (s_rx_byte == first_magic_reg) begin
                fill_next  = FW'(1);
                total_next = '0;
                xor_next   = s_rx_byte;
            end else begin
                drop = 1'b1;
            end
        end
        if (drop) begin
            fill_next  = '0;
            total_next = '0;
            idle_next  = 8'd0;
            xor_next   = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            total_reg <= '0;
            idle_reg  <= 8'd0;
            xor_reg   <= 8'd0;
        end else begin
            fill_reg  <= fill_next;
            total_reg <= total_next;
            idle_reg  <= idle_next;
            xor_reg   <= xor_next;
        end
    end

    always_ff @(posedge aclk) begin
        ver_reg   <= ver_next;
        cmd_reg   <= cmd_next;
        seq_reg   <= seq_next;
        flags_reg <= flags_next;
        len_reg   <= len_next;
        if (byte_done) begin
            good_reg <= ((xor_reg ^ s_rx_byte) == 8'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.load_summary) begin
            idx_reg <= '0;
        end else if (cmd.load_payload) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    mhpd_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (s_rx_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_payload || cmd.load_summary) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_payload) begin
            out_summary_reg <= 1'b0;
            out_byte_reg    <= ram_rdata;
            out_index_reg   <= 6'(idx_reg);
            out_status_reg  <= 1'b0;
            out_cmd_reg     <= 8'd0;
            out_seq_reg     <= 8'd0;
            out_flags_reg   <= 8'd0;
            out_count_reg   <= 6'd0;
        end else if (cmd.load_summary) begin
            out_summary_reg <= 1'b1;
            out_byte_reg    <= 8'd0;
            out_index_reg   <= 6'd0;
            out_status_reg  <= !good_reg;
            out_cmd_reg     <= cmd_reg;
            out_seq_reg     <= seq_reg;
            out_flags_reg   <= flags_reg;
            out_count_reg   <= len_reg[5:0];
        end
    end

    assign status.frame_done  = byte_done;
    assign status.done_good   = ((xor_reg ^ s_rx_byte) == 8'd0);
    assign status.has_payload = (len_reg != 8'd0);
    assign status.last_byte   = ((9'(idx_reg) + 9'd1) == {1'b0, len_reg});
    assign status.slot_free   = !out_valid_reg || m_ready;

    assign m_valid           = out_valid_reg;
    assign m_is_summary      = out_summary_reg;
    assign m_payload_byte    = out_byte_reg;
    assign m_byte_index      = out_index_reg;
    assign m_frame_status    = out_status_reg;
    assign m_command_code    = out_cmd_reg;
    assign m_sequence_number = out_seq_reg;
    assign m_header_flags    = out_flags_reg;
    assign m_payload_count   = out_count_reg;
    assign m_last            = out_summary_reg;

endmodule

`default_nettype wire

>>> rtl/magic_header_packet_deframer.sv
`default_nettype none
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_req_type, s_rx_byte
// m_        out        m_valid / m_ready    is_summary .. last (nine fields)
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// An input word is taken as soon as it is offered while hunting or filling a frame.
// A completed frame with a good checksum flushes its payload words from the RAM,
// each by a RAM read and then an output load; the summary follows; m_ready stalls it.
// s_ready stays low for the whole flush; cfg_ready is always high.
// aresetn is synchronous, active low; no clearing pass, the store is only read
// where the current frame wrote it.

module magic_header_packet_deframer #(
    parameter int BUFFER_BYTES = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_req_type,
    input  wire logic [7:0] s_rx_byte,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_is_summary,
    output logic [7:0]      m_payload_byte,
    output logic [5:0]      m_byte_index,
    output logic            m_frame_status,
    output logic [7:0]      m_command_code,
    output logic [7:0]      m_sequence_number,
    output logic [7:0]      m_header_flags,
    output logic [5:0]      m_payload_count,
    output logic            m_last,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    mhpd_pkg::cmd_t    cmd;
    mhpd_pkg::status_t status;

    // config registers take a write in any cycle
    assign cfg_ready = 1'b1;
    assign s_ready   = cmd.take;

    // sequencer: hunt/fill, then flush payload words and the summary
    mhpd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cmd     (cmd)
    );

    // parser registers, frame RAM and output register
    mhpd_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_valid           (s_valid),
        .s_req_type        (s_req_type),
        .s_rx_byte         (s_rx_byte),
        .cfg_write         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_is_summary      (m_is_summary),
        .m_payload_byte    (m_payload_byte),
        .m_byte_index      (m_byte_index),
        .m_frame_status    (m_frame_status),
        .m_command_code    (m_command_code),
        .m_sequence_number (m_sequence_number),
        .m_header_flags    (m_header_flags),
        .m_payload_count   (m_payload_count),
        .m_last            (m_last)
    );

endmodule

`default_nettype wire

>>> rtl/mhpd_checker.sv
`default_nettype none

module mhpd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_is_summary,
    input wire logic [7:0] m_payload_byte,
    input wire logic [5:0] m_byte_index,
    input wire logic       m_frame_status,
    input wire logic [7:0] m_command_code,
    input wire logic       m_last
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload_byte) &&
        $stable(m_byte_index) && $stable(m_is_summary))
        else $error("result word changed under stall");

    // a payload word means a flush is running, so no input is taken
    a_flush_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_summary |-> !s_ready)
        else $error("input ready during payload flush");

    a_payload_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_summary |-> !m_last && !m_frame_status &&
        (m_command_code == 8'd0))
        else $error("payload word carries summary fields");

    a_summary_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_summary |-> m_last && (m_payload_byte == 8'd0) &&
        (m_byte_index == 6'd0))
        else $error("summary word malformed");

endmodule

bind magic_header_packet_deframer mhpd_checker u_chk (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_is_summary   (m_is_summary),
    .m_payload_byte (m_payload_byte),
    .m_byte_index   (m_byte_index),
    .m_frame_status (m_frame_status),
    .m_command_code (m_command_code),
    .m_last         (m_last)
);

`default_nettype wire

>>> test/magic_header_packet_deframer_test.sv
`default_nettype none

module magic_header_packet_deframer_test;

    localparam int BUFFER_BYTES = 64;
    localparam int MAX_PAYLOAD  = BUFFER_BYTES - mhpd_pkg::HDR_BYTES - 1;  // 55
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 400;   // long m_ready hold-off, in cycles
    localparam int DRAIN_CYCLES = 8;     // settle time once the results are in

    // Input word kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_IDLE = 1'b1;

    // One output word, fields in port order
    typedef struct packed {
        logic       is_summary;
        logic [7:0] payload_byte;
        logic [5:0] byte_index;
        logic       frame_status;
        logic [7:0] command_code;
        logic [7:0] sequence_number;
        logic [7:0] header_flags;
        logic [5:0] payload_count;
        logic       last;
    } result_t;

    // Tracks the deframer's state and holds the output words still owed by it.
    class deframe_scoreboard;
        logic [7:0]  sync_a;
        logic [7:0]  sync_b;
        logic [7:0]  want_version;
        logic [7:0]  idle_cap;
        int unsigned held;         // bytes of the current frame, 0 = hunting
        int unsigned frame_len;    // whole frame length, 0 = not known yet
        int unsigned quiet_run;    // idle ticks in a row inside a frame
        logic [7:0]  xor_acc;
        logic [7:0]  held_bytes [BUFFER_BYTES];
        result_t     pending_results [$];
        int          errors;

        function new();
            sync_a       = 8'd170;
            sync_b       = 8'd85;
            want_version = 8'd1;
            idle_cap     = 8'd100;
            errors       = 0;
            foreach (held_bytes[i]) held_bytes[i] = 8'd0;
            abandon();
        endfunction

        function void abandon();
            held      = 0;
            frame_len = 0;
            quiet_run = 0;
            xor_acc   = 8'd0;
        endfunction

        // Header mismatch: the offending byte may open a new frame.
        function void restart(logic [7:0] b);
            if (b == sync_a) begin
                held_bytes[0] = b;
                held          = 1;
                frame_len     = 0;
                xor_acc       = b;
            end else begin
                abandon();
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] value);
            case (idx)
                mhpd_pkg::CFG_FIRST_MAGIC:  sync_a = value;
                mhpd_pkg::CFG_SECOND_MAGIC: sync_b = value;
                mhpd_pkg::CFG_VERSION:      want_version = value;
                mhpd_pkg::CFG_IDLE_LIMIT:   idle_cap = value;
                default: ;
            endcase
        endfunction

        // Frame complete: payload words if the checksum holds, then the summary.
        function void close_frame();
            int unsigned len;
            result_t     r;
            len = frame_len - mhpd_pkg::HDR_BYTES - 1;
            if (xor_acc == 8'd0) begin
                for (int i = 0; i < len; i++) begin
                    r              = '0;
                    r.payload_byte = held_bytes[mhpd_pkg::HDR_BYTES + i];
                    r.byte_index   = 6'(i);
                    pending_results.push_back(r);
                end
            end
            r                 = '0;
            r.is_summary      = 1'b1;
            r.frame_status    = (xor_acc != 8'd0);
            r.command_code    = held_bytes[mhpd_pkg::POS_CMD];
            r.sequence_number = held_bytes[mhpd_pkg::POS_SEQ];
            r.header_flags    = held_bytes[mhpd_pkg::POS_FLAGS];
            r.payload_count   = 6'(len);
            r.last            = 1'b1;
            pending_results.push_back(r);
            abandon();
        endfunction

        // Returns 0 for a word that the deframer merely ignores.
        function bit take_rx_word(logic kind, logic [7:0] b);
            int unsigned len;
            if (kind == REQ_IDLE) begin
                if (held == 0) return 1'b0;
                if (quiet_run < 255) quiet_run++;
                if (quiet_run >= idle_cap) abandon();
                return 1'b1;
            end
            quiet_run = 0;
            if (held == 0) begin
                if (b != sync_a) return 1'b0;
                held_bytes[0] = b;
                held          = 1;
                xor_acc       = b;
                return 1'b1;
            end
            if ((held == 1 && b != sync_b) || held >= BUFFER_BYTES) begin
                restart(b);
                return 1'b1;
            end
            held_bytes[held] = b;
            held++;
            xor_acc ^= b;
            // version is rechecked on every later byte
            if (held >= 3 && held_bytes[mhpd_pkg::POS_VERSION] != want_version) begin
                restart(b);
                return 1'b1;
            end
            if (held >= mhpd_pkg::HDR_BYTES && frame_len == 0) begin
                len = {held_bytes[mhpd_pkg::POS_LEN_LO + 1],
                       held_bytes[mhpd_pkg::POS_LEN_LO]};
                if (mhpd_pkg::HDR_BYTES + len + 1 > BUFFER_BYTES) begin
                    restart(b);
                    return 1'b1;
                end
                frame_len = mhpd_pkg::HDR_BYTES + len + 1;
            end
            if (frame_len != 0 && held == frame_len) close_frame();
            return 1'b1;
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result_word(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                $error("output word with none expected: %h", got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("is_summary", want.is_summary, got.is_summary);
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("byte_index", want.byte_index, got.byte_index);
            compare_field("frame_status", want.frame_status, got.frame_status);
            compare_field("command_code", want.command_code, got.command_code);
            compare_field("sequence_number", want.sequence_number, got.sequence_number);
            compare_field("header_flags", want.header_flags, got.header_flags);
            compare_field("payload_count", want.payload_count, got.payload_count);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;

    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_req_type = REQ_BYTE;
    logic [7:0] s_rx_byte = 8'd0;

    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_is_summary;
    logic [7:0] m_payload_byte;
    logic [5:0] m_byte_index;
    logic       m_frame_status;
    logic [7:0] m_command_code;
    logic [7:0] m_sequence_number;
    logic [7:0] m_header_flags;
    logic [5:0] m_payload_count;
    logic       m_last;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = mhpd_pkg::CFG_FIRST_MAGIC;
    logic [7:0] cfg_data = 8'd0;

    deframe_scoreboard sb = new();

    int unsigned cycle_count  = 0;
    int unsigned busy_items   = 0;  // words that moved the deframer's state
    bit          send_idling  = 1'b0;
    bit          recv_idling  = 1'b0;
    bit          hold_request = 1'b0;
    int          idle_odds    = 0;  // percent chance of idle ticks between frame bytes

    magic_header_packet_deframer #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_is_summary      (m_is_summary),
        .m_payload_byte    (m_payload_byte),
        .m_byte_index      (m_byte_index),
        .m_frame_status    (m_frame_status),
        .m_command_code    (m_command_code),
        .m_sequence_number (m_sequence_number),
        .m_header_flags    (m_header_flags),
        .m_payload_count   (m_payload_count),
        .m_last            (m_last),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("magic_header_packet_deframer regression: fail");
            $finish;
        end
    end

    // Output monitor: every accepted word goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result_word({m_is_summary, m_payload_byte, m_byte_index,
                                  m_frame_status, m_command_code, m_sequence_number,
                                  m_header_flags, m_payload_count, m_last});
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // m_ready driver. A hold request drops ready for the LONG_HOLD hold-off so the
    // frame flush backs up and s_ready falls while the sender keeps offering.
    initial begin : ready_driver
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (recv_idling && $urandom_range(0, 99) < 20) begin
                m_ready <= 1'b0;
                stall_left = pick_gap() - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one word and hold it until taken. Called at a falling edge; returns
    // at a falling edge with valid either low (gap) or still high, in which case
    // the caller must present the next word in the same step or drop valid.
    task automatic send_word(input logic kind, input logic [7:0] value);
        int gap;
        s_valid    <= 1'b1;
        s_req_type <= kind;
        s_rx_byte  <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (sb.take_rx_word(kind, value)) busy_items++;
        @(negedge aclk);
        if (send_idling && $urandom_range(0, 99) < 30) begin
            gap = pick_gap();
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic send_idles(input int count);
        repeat (count) send_word(REQ_IDLE, 8'($urandom));
    endtask

    // Build a frame with the current sync, version and a 16-bit length.
    // An oversized length sends only the header; cut > 0 truncates the frame.
    task automatic send_frame(input int unsigned len, input bit bad_sum,
                              input int unsigned cut);
        logic [7:0] frame_bytes [$];
        logic [7:0] sum;
        int         run_max;
        frame_bytes = {sb.sync_a, sb.sync_b, sb.want_version, 8'($urandom),
                       8'($urandom), 8'($urandom), len[7:0], len[15:8]};
        if (mhpd_pkg::HDR_BYTES + len + 1 <= BUFFER_BYTES) begin
            repeat (len) frame_bytes.push_back(8'($urandom));
            sum = 8'd0;
            foreach (frame_bytes[i]) sum ^= frame_bytes[i];
            if (bad_sum) sum ^= 8'($urandom_range(1, 255));
            frame_bytes.push_back(sum);
        end
        while (cut != 0 && frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        run_max = (sb.idle_cap > 4) ? 3 : int'(sb.idle_cap) - 1;
        foreach (frame_bytes[i]) begin
            // idle runs kept short of the limit so the frame survives
            if (i != 0 && run_max > 0 && $urandom_range(0, 99) < idle_odds)
                send_idles($urandom_range(1, run_max));
            send_word(REQ_BYTE, frame_bytes[i]);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(idx, value);
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [7:0] first, input logic [7:0] second,
                              input logic [7:0] version, input logic [7:0] limit);
        write_reg(mhpd_pkg::CFG_FIRST_MAGIC, first);
        write_reg(mhpd_pkg::CFG_SECOND_MAGIC, second);
        write_reg(mhpd_pkg::CFG_VERSION, version);
        write_reg(mhpd_pkg::CFG_IDLE_LIMIT, limit);
        cfg_valid <= 1'b0;
    endtask

    // Sender pause: wait out every owed word, then let the block settle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Random traffic until 'count' more state-moving words have gone in.
    task automatic random_traffic(input int unsigned count);
        int unsigned stop_at;
        int unsigned len;
        int          roll;
        int          pick;
        stop_at = busy_items + count;
        while (busy_items < stop_at) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                // complete frame, mostly short payloads, some with a bad checksum
                pick = $urandom_range(0, 99);
                if (pick < 80)      len = $urandom_range(0, 8);
                else if (pick < 95) len = $urandom_range(9, MAX_PAYLOAD - 1);
                else                len = MAX_PAYLOAD;
                send_frame(len, $urandom_range(0, 99) < 15, 0);
            end else if (roll < 78) begin
                // length that cannot fit the buffer, low byte or high byte
                if ($urandom_range(0, 1)) len = $urandom_range(MAX_PAYLOAD + 1, 255);
                else                      len = $urandom_range(256, 65535);
                send_frame(len, 1'b0, 0);
            end else if (roll < 86) begin
                // partial frame, then silence long enough to drop it if the limit is low
                send_frame($urandom_range(0, 8), 1'b0, $urandom_range(1, 8));
                if (sb.idle_cap <= 40) send_idles(sb.idle_cap);
                else                   send_idles($urandom_range(1, 4));
            end else if (roll < 93) begin
                // header broken at the second or third byte
                send_word(REQ_BYTE, sb.sync_a);
                if ($urandom_range(0, 1)) send_word(REQ_BYTE, sb.sync_b);
                send_word(REQ_BYTE, 8'($urandom));
            end else begin
                send_word(1'($urandom_range(0, 1)), 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings, directed first
        send_idling = 1'b1;
        recv_idling = 1'b1;
        idle_odds   = 10;
        send_word(REQ_IDLE, 8'hFF);          // idle while hunting
        send_word(REQ_BYTE, 8'hFF);
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_BYTE, sb.sync_a);
        send_word(REQ_BYTE, sb.sync_a);      // bad second sync that restarts
        send_word(REQ_BYTE, sb.sync_b);
        send_word(REQ_BYTE, sb.want_version ^ 8'h03);  // wrong version
        send_frame(0, 1'b0, 0);              // empty payload
        send_frame(256, 1'b0, 0);            // length too large via high byte
        random_traffic(40);

        // Low extremes on the syncs' complement, idle limit of one, no idling
        wait_drained();
        set_config(8'h00, 8'hFF, 8'hFF, 8'd1);
        send_idling = 1'b0;
        recv_idling = 1'b0;
        random_traffic(50);

        // High extremes; long receiver hold-off backs the block up
        wait_drained();
        set_config(8'hFF, 8'h00, 8'h00, 8'd255);
        send_idling  = 1'b1;
        recv_idling  = 1'b1;
        idle_odds    = 20;
        send_frame(40, 1'b0, 0);
        // flush of the long frame is now running; hold it while the next frame waits
        hold_request = 1'b1;
        send_frame(20, 1'b0, 0);
        send_frame(2, 1'b0, 0);
        random_traffic(8);

        // Random settings with a small idle limit
        wait_drained();
        set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(2, 12)));
        idle_odds = 15;
        random_traffic(60);

        wait_drained();
        if (sb.errors == 0) begin
            $display("magic_header_packet_deframer regression: pass");
        end else begin
            $display("magic_header_packet_deframer regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
